// ===== rtl/spn_ready_queue_top_macros.svh =====
// Assertion helpers used by the ready queue top RTL.
`ifndef SPN_READY_QUEUE_TOP_MACROS_SVH
`define SPN_READY_QUEUE_TOP_MACROS_SVH

`define SPNQ_ASSERT_NOW(lbl, clk, rst, ant, con, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) \
      else $error(msg);

`define SPNQ_ASSERT_NEXT(lbl, clk, rst, ant, con, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) \
      else $error(msg);

`endif

// ===== rtl/spnq_pkg.sv =====
package spnq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;

   localparam logic CSR_IDX_ORDER_POLICY = 1'b0;

   localparam logic POLICY_FIFO = 1'b0;
   localparam logic POLICY_SPN  = 1'b1;

   localparam logic MODE_PUSH = 1'b0;
   localparam logic MODE_POP  = 1'b1;

   typedef struct packed {
      logic [7:0]  pid;
      logic [15:0] svc;
      logic [15:0] arr;
   } entry_type;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   function automatic logic goes_ahead(input entry_type nw, input entry_type cur);
      goes_ahead = (nw.svc < cur.svc) || ((nw.svc == cur.svc) && (nw.arr <= cur.arr));
   endfunction

endpackage

// ===== rtl/spnq_store.sv =====
module spnq_store #(
   parameter int DEPTH = spnq_pkg::DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  spnq_pkg::entry_type wr_data,
   input  logic [AW-1:0]       rd_addr,
   output spnq_pkg::entry_type rd_data
);

   spnq_pkg::entry_type mem [DEPTH];
   spnq_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/spn_ready_queue_top.sv =====
// Channel   Direction  Handshake            Word
// req       in         req_valid/req_stall  mode, process id, service, arrival
// rsp       out        rsp_valid/rsp_stall  popped entry, drop flag, occupancy
// csr       in/out     psel/penable/pready  order policy register
//
// A pop, a FIFO push or a push to a full queue is accepted in ST_IDLE and completes
// in ST_SCAN, where the registered memory read of the head is used.
// An ordered push scans the stored entries from the head, one memory read per
// cycle, and completes once every stored entry has been read.
// Reset is synchronous and empties the queue; the policy returns to FIFO.
// A stalled result word holds the final step until the output register frees.
`include "spn_ready_queue_top_macros.svh"

module spn_ready_queue_top #(
   parameter int DEPTH = spnq_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_mode,
   input  logic [7:0]                    req_process_id,
   input  logic [15:0]                   req_service_time,
   input  logic [15:0]                   req_arrival_time,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_out_valid,
   output logic [7:0]                    rsp_out_process_id,
   output logic [15:0]                   rsp_out_service_time,
   output logic [15:0]                   rsp_out_arrival_time,
   output logic                          rsp_push_dropped,
   output logic [4:0]                    rsp_occupancy,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [spnq_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [spnq_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [spnq_pkg::CSR_DATA_W-1:0] prdata,
   output logic                          pready
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;

   spnq_pkg::state_type state_ff, state_in;
   logic [AW-1:0]       head_ff, head_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [AW-1:0]       ptr_ff, ptr_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic                ins_ff, ins_in;
   logic                pop_ff, pop_in;
   logic                policy_ff, policy_in;
   spnq_pkg::entry_type carry_ff, carry_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_valid_ff, out_valid_in;
   spnq_pkg::entry_type out_entry_ff, out_entry_in;
   logic                dropped_ff, dropped_in;
   logic [4:0]          occ_ff, occ_in;

   logic                mem_wr_en;
   logic [AW-1:0]       mem_wr_addr;
   spnq_pkg::entry_type mem_wr_data;
   logic [AW-1:0]       mem_rd_addr;
   spnq_pkg::entry_type mem_rd_data;

   logic                req_accept, out_free, full, at_end, finish, commit;
   logic [AW-1:0]       nxt_ptr, tail;
   logic [SW-1:0]       tail_sum, tail_wrap;
   logic [CW+4:0]       occ_wide;
   logic                csr_write;

   spnq_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign prdata    = (paddr[2] == spnq_pkg::CSR_IDX_ORDER_POLICY) ?
                      {{(spnq_pkg::CSR_DATA_W-1){1'b0}}, policy_ff} : '0;

   assign req_stall  = (state_ff != spnq_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign full     = (count_ff == CW'(DEPTH));
   assign at_end   = (idx_ff == count_ff);
   assign finish   = pop_ff || full || (policy_ff == spnq_pkg::POLICY_FIFO) || at_end;
   assign commit   = (state_ff == spnq_pkg::ST_SCAN) && finish && out_free;
   assign nxt_ptr  = (ptr_ff == AW'(DEPTH - 1)) ? '0 : ptr_ff + AW'(1);
   assign tail_sum = SW'(head_ff) + SW'(count_ff);
   assign tail_wrap = (tail_sum >= SW'(DEPTH)) ? tail_sum - SW'(DEPTH) : tail_sum;
   assign tail     = tail_wrap[AW-1:0];

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      idx_in       = idx_ff;
      ins_in       = ins_ff;
      pop_in       = pop_ff;
      carry_in     = carry_ff;
      policy_in    = policy_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      out_valid_in = out_valid_ff;
      out_entry_in = out_entry_ff;
      dropped_in   = dropped_ff;
      occ_in       = occ_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = ptr_ff;
      mem_wr_data  = carry_ff;
      mem_rd_addr  = head_ff;
      occ_wide     = '0;

      if (csr_write && (paddr[2] == spnq_pkg::CSR_IDX_ORDER_POLICY)) begin
         policy_in = pwdata[0];
      end

      case (state_ff)
         spnq_pkg::ST_IDLE: begin
            mem_rd_addr = head_ff;
            if (req_accept) begin
               state_in = spnq_pkg::ST_SCAN;
               pop_in   = (req_mode == spnq_pkg::MODE_POP);
               carry_in = '{pid: req_process_id, svc: req_service_time,
                            arr: req_arrival_time};
               idx_in   = '0;
               ptr_in   = head_ff;
               ins_in   = 1'b0;
            end
         end
         spnq_pkg::ST_SCAN: begin
            mem_rd_addr = finish ? ptr_ff : nxt_ptr;
            if (!finish) begin
               if (ins_ff || spnq_pkg::goes_ahead(carry_ff, mem_rd_data)) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = ptr_ff;
                  mem_wr_data = carry_ff;
                  carry_in    = mem_rd_data;
                  ins_in      = 1'b1;
               end
               ptr_in = nxt_ptr;
               idx_in = idx_ff + CW'(1);
            end else if (commit) begin
               state_in     = spnq_pkg::ST_IDLE;
               rsp_valid_in = 1'b1;
               out_valid_in = 1'b0;
               out_entry_in = '0;
               dropped_in   = 1'b0;
               if (pop_ff) begin
                  if (count_ff != '0) begin
                     out_valid_in = 1'b1;
                     out_entry_in = mem_rd_data;
                     head_in      = nxt_ptr;
                     count_in     = count_ff - CW'(1);
                  end
               end else if (full) begin
                  dropped_in = 1'b1;
               end else begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = tail;
                  mem_wr_data = carry_ff;
                  count_in    = count_ff + CW'(1);
               end
               occ_wide = {5'b0, count_in};
               occ_in   = occ_wide[4:0];
            end
         end
         default: begin
            state_in = spnq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spnq_pkg::ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         ptr_ff       <= '0;
         idx_ff       <= '0;
         ins_ff       <= 1'b0;
         pop_ff       <= 1'b0;
         policy_ff    <= spnq_pkg::POLICY_FIFO;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         idx_ff       <= idx_in;
         ins_ff       <= ins_in;
         pop_ff       <= pop_in;
         policy_ff    <= policy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      carry_ff     <= carry_in;
      out_valid_ff <= out_valid_in;
      out_entry_ff <= out_entry_in;
      dropped_ff   <= dropped_in;
      occ_ff       <= occ_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_out_valid        = out_valid_ff;
   assign rsp_out_process_id   = out_entry_ff.pid;
   assign rsp_out_service_time = out_entry_ff.svc;
   assign rsp_out_arrival_time = out_entry_ff.arr;
   assign rsp_push_dropped     = dropped_ff;
   assign rsp_occupancy        = occ_ff;

   `SPNQ_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(DEPTH), "count exceeds depth")
   `SPNQ_ASSERT_NOW(a_idle_no_write, clock, reset, state_ff == spnq_pkg::ST_IDLE, !mem_wr_en, "memory written while idle")
   `SPNQ_ASSERT_NEXT(a_accept_scan, clock, reset, req_accept, (state_ff == spnq_pkg::ST_SCAN) && (idx_ff == '0), "accept did not start a scan")
   `SPNQ_ASSERT_NEXT(a_pop_count, clock, reset, commit && pop_ff && (count_ff != '0), count_ff == $past(count_ff) - CW'(1), "pop did not reduce count")
   `SPNQ_ASSERT_NOW(a_scan_free, clock, reset, commit, out_free, "result loaded over a waiting word")

endmodule
